@@ src/priority_ready_queue_scheduler_core_defines.svh @@
// Assertion macros for the ready-queue scheduler.
// Needs signals clk and rst in the scope that uses them.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_CORE_DEFINES_SVH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define PRQS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds in a cycle -> consequent holds in the next cycle
`define PRQS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/prqs_pkg.sv @@
// Shared constants, memory request types and helpers for the scheduler.
// No dependencies.
`default_nettype none
package prqs_pkg;

  localparam int NUM_TASKS  = 16;
  localparam int NUM_LEVELS = 8;
  localparam int TASK_W     = $clog2(NUM_TASKS);
  localparam int LEVEL_W    = $clog2(NUM_LEVELS);
  localparam int OP_W       = 2;
  localparam int ID_W       = 4;
  localparam int PRIO_W     = 3;
  localparam int STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd2;

  typedef struct packed {
    logic               we;
    logic [TASK_W-1:0]  waddr;
    logic [TASK_W-1:0]  wdata;
    logic [TASK_W-1:0]  raddr;
  } link_req_t;

  typedef struct packed {
    logic               we;
    logic [TASK_W-1:0]  waddr;
    logic [LEVEL_W-1:0] wdata;
    logic [TASK_W-1:0]  raddr;
  } tlev_req_t;

  typedef struct packed {
    logic               we;
    logic [LEVEL_W-1:0] waddr;
    logic [TASK_W-1:0]  wdata;
    logic [LEVEL_W-1:0] raddr;
  } lvl_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TASK_W-1:0]  next;
    logic [TASK_W-1:0]  prev;
    logic [TASK_W-1:0]  head;
    logic [TASK_W-1:0]  tail;
  } mem_rsp_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [PRIO_W-1:0] v);
    if (int'(v) >= NUM_LEVELS) begin
      return LEVEL_W'(NUM_LEVELS - 1);
    end
    return LEVEL_W'(v);
  endfunction

  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    return int'(id) < NUM_TASKS;
  endfunction

  function automatic logic [LEVEL_W-1:0] top_level(input logic [NUM_LEVELS-1:0] mask);
    logic [LEVEL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (mask[i]) begin
        lvl = LEVEL_W'(i);
      end
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

@@ src/priority_ready_queue_scheduler_core.sv @@
// Top level of the ready-queue scheduler: sequencer plus link and level memories.
// Depends on prqs_pkg, prqs_ctrl and prqs_ram.
//
//  channel   | handshake          | words
//  ----------+--------------------+---------------------------------------------
//  command   | start & !busy      | opcode task_id task_priority current_valid
//            |                    | current_priority
//  result    | done (one cycle)   | status preempt_request any_ready next_task
//            |                    | next_priority
//
// One command word at a time. Query, ignored and rejected words only read the
// head; remove unlinks, add pushes, rotate does both, by read-modify-write of
// the memories. The result is shown for one cycle with done high. rst is
// synchronous; it empties all levels. The receiver cannot stall.
`default_nettype none
module priority_ready_queue_scheduler_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [prqs_pkg::OP_W-1:0]      opcode,
  input  wire logic [prqs_pkg::ID_W-1:0]      task_id,
  input  wire logic [prqs_pkg::PRIO_W-1:0]    task_priority,
  input  wire logic                           current_valid,
  input  wire logic [prqs_pkg::PRIO_W-1:0]    current_priority,
  output logic                                done,
  output logic      [prqs_pkg::STATUS_W-1:0]  status,
  output logic                                preempt_request,
  output logic                                any_ready,
  output logic      [prqs_pkg::ID_W-1:0]      next_task,
  output logic      [prqs_pkg::PRIO_W-1:0]    next_priority
);
  import prqs_pkg::*;

  tlev_req_t level_req;
  link_req_t next_req;
  link_req_t prev_req;
  lvl_req_t  head_req;
  lvl_req_t  tail_req;
  mem_rsp_t  rsp;

  prqs_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .opcode           (opcode),
    .task_id          (task_id),
    .task_priority    (task_priority),
    .current_valid    (current_valid),
    .current_priority (current_priority),
    .busy             (busy),
    .done             (done),
    .status           (status),
    .preempt_request  (preempt_request),
    .any_ready        (any_ready),
    .next_task        (next_task),
    .next_priority    (next_priority),
    .level_req        (level_req),
    .next_req         (next_req),
    .prev_req         (prev_req),
    .head_req         (head_req),
    .tail_req         (tail_req),
    .rsp              (rsp)
  );

  prqs_ram #(.WIDTH(LEVEL_W), .DEPTH(NUM_TASKS)) u_level_ram (
    .clk   (clk),
    .we    (level_req.we),
    .waddr (level_req.waddr),
    .wdata (level_req.wdata),
    .raddr (level_req.raddr),
    .rdata (rsp.level)
  );

  prqs_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_next_ram (
    .clk   (clk),
    .we    (next_req.we),
    .waddr (next_req.waddr),
    .wdata (next_req.wdata),
    .raddr (next_req.raddr),
    .rdata (rsp.next)
  );

  prqs_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_req.we),
    .waddr (prev_req.waddr),
    .wdata (prev_req.wdata),
    .raddr (prev_req.raddr),
    .rdata (rsp.prev)
  );

  prqs_ram #(.WIDTH(TASK_W), .DEPTH(NUM_LEVELS)) u_head_ram (
    .clk   (clk),
    .we    (head_req.we),
    .waddr (head_req.waddr),
    .wdata (head_req.wdata),
    .raddr (head_req.raddr),
    .rdata (rsp.head)
  );

  prqs_ram #(.WIDTH(TASK_W), .DEPTH(NUM_LEVELS)) u_tail_ram (
    .clk   (clk),
    .we    (tail_req.we),
    .waddr (tail_req.waddr),
    .wdata (tail_req.wdata),
    .raddr (tail_req.raddr),
    .rdata (rsp.tail)
  );

endmodule
`default_nettype wire

@@ src/prqs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module prqs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/prqs_ctrl.sv @@
// Sequencer for the scheduler: read-modify-write of the link and level memories,
// ready bitmap, queued flags and result. Depends on prqs_pkg and the defines header.
`default_nettype none
`include "priority_ready_queue_scheduler_core_defines.svh"
module prqs_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [prqs_pkg::OP_W-1:0]      opcode,
  input  wire logic [prqs_pkg::ID_W-1:0]      task_id,
  input  wire logic [prqs_pkg::PRIO_W-1:0]    task_priority,
  input  wire logic                           current_valid,
  input  wire logic [prqs_pkg::PRIO_W-1:0]    current_priority,
  output logic                                busy,
  output logic                                done,
  output logic      [prqs_pkg::STATUS_W-1:0]  status,
  output logic                                preempt_request,
  output logic                                any_ready,
  output logic      [prqs_pkg::ID_W-1:0]      next_task,
  output logic      [prqs_pkg::PRIO_W-1:0]    next_priority,
  output prqs_pkg::tlev_req_t                 level_req,
  output prqs_pkg::link_req_t                 next_req,
  output prqs_pkg::link_req_t                 prev_req,
  output prqs_pkg::lvl_req_t                  head_req,
  output prqs_pkg::lvl_req_t                  tail_req,
  input  wire prqs_pkg::mem_rsp_t             rsp
);
  import prqs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LOOKUP  = 8'b0000_0010,
    S_LINKS   = 8'b0000_0100,
    S_UNLINK  = 8'b0000_1000,
    S_PUSH_RD = 8'b0001_0000,
    S_PUSH_WR = 8'b0010_0000,
    S_HEAD_RD = 8'b0100_0000,
    S_RESULT  = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [OP_W-1:0]     op;
  logic [TASK_W-1:0]   tid;
  logic [LEVEL_W-1:0]  lvl;
  logic [TASK_W-1:0]   nx;
  logic [TASK_W-1:0]   pv;
  logic [STATUS_W-1:0] st;
  logic [STATUS_W-1:0] st_next;
  logic                preempt;
  logic                preempt_next;
  logic [NUM_LEVELS-1:0] mask;
  logic [NUM_TASKS-1:0]  queued;
  logic [TASK_W-1:0]   in_tid;
  logic                in_ok;
  logic [LEVEL_W-1:0]  in_lvl;
  logic [LEVEL_W-1:0]  top;
  logic                is_head;
  logic                is_tail;

  assign in_tid  = task_id[TASK_W-1:0];
  assign in_ok   = id_in_range(task_id);
  assign in_lvl  = clamp_level(task_priority);
  assign top     = top_level(mask);
  assign is_head = rsp.head == tid;
  assign is_tail = rsp.tail == tid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_QUERY || !in_ok) begin
            state_next = S_HEAD_RD;
          end else if (opcode == OP_ADD) begin
            state_next = queued[in_tid] ? S_HEAD_RD : S_PUSH_RD;
          end else begin
            state_next = queued[in_tid] ? S_LOOKUP : S_HEAD_RD;
          end
        end
      end
      S_LOOKUP:  state_next = S_LINKS;
      S_LINKS:   state_next = S_UNLINK;
      S_UNLINK:  state_next = (op == OP_ROTATE) ? S_PUSH_RD : S_HEAD_RD;
      S_PUSH_RD: state_next = S_PUSH_WR;
      S_PUSH_WR: state_next = S_HEAD_RD;
      S_HEAD_RD: state_next = S_RESULT;
      S_RESULT:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    st_next      = ST_OK;
    preempt_next = 1'b0;
    if (opcode != OP_QUERY) begin
      if (!in_ok) begin
        st_next = ST_NOT_QUEUED;
      end else if (opcode == OP_ADD) begin
        if (queued[in_tid]) begin
          st_next = ST_QUEUED;
        end else begin
          preempt_next = current_valid && (in_lvl > clamp_level(current_priority));
        end
      end else if (!queued[in_tid]) begin
        st_next = ST_NOT_QUEUED;
      end
    end
  end

  always_comb begin
    level_req       = '0;
    next_req        = '0;
    prev_req        = '0;
    head_req        = '0;
    tail_req        = '0;
    level_req.raddr = tid;
    next_req.raddr  = tid;
    prev_req.raddr  = tid;
    head_req.raddr  = (state == S_HEAD_RD) ? top : rsp.level;
    tail_req.raddr  = (state == S_PUSH_RD) ? lvl : rsp.level;
    case (state)
      S_UNLINK: begin
        if (is_head && !is_tail) begin
          head_req.we    = 1'b1;
          head_req.waddr = lvl;
          head_req.wdata = nx;
        end else if (is_tail && !is_head) begin
          tail_req.we    = 1'b1;
          tail_req.waddr = lvl;
          tail_req.wdata = pv;
        end else if (!is_head && !is_tail) begin
          next_req.we    = 1'b1;
          next_req.waddr = pv;
          next_req.wdata = nx;
          prev_req.we    = 1'b1;
          prev_req.waddr = nx;
          prev_req.wdata = pv;
        end
      end
      S_PUSH_WR: begin
        level_req.we    = 1'b1;
        level_req.waddr = tid;
        level_req.wdata = lvl;
        tail_req.we     = 1'b1;
        tail_req.waddr  = lvl;
        tail_req.wdata  = tid;
        if (!mask[lvl]) begin
          head_req.we    = 1'b1;
          head_req.waddr = lvl;
          head_req.wdata = tid;
        end else begin
          next_req.we    = 1'b1;
          next_req.waddr = rsp.tail;
          next_req.wdata = tid;
          prev_req.we    = 1'b1;
          prev_req.waddr = tid;
          prev_req.wdata = rsp.tail;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mask   <= '0;
      queued <= '0;
    end else begin
      state <= state_next;
      if (state == S_UNLINK) begin
        queued[tid] <= 1'b0;
        if (is_head && is_tail) begin
          mask[lvl] <= 1'b0;
        end
      end
      if (state == S_PUSH_WR) begin
        queued[tid] <= 1'b1;
        mask[lvl]   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op      <= opcode;
        tid     <= in_tid;
        lvl     <= in_lvl;
        st      <= st_next;
        preempt <= preempt_next;
      end
      S_LINKS: begin
        lvl <= rsp.level;
        nx  <= rsp.next;
        pv  <= rsp.prev;
      end
      default: begin
      end
    endcase
  end

  assign busy            = state != S_IDLE;
  assign done            = state == S_RESULT;
  assign status          = st;
  assign preempt_request = preempt;
  assign any_ready       = |mask;
  assign next_task       = any_ready ? ID_W'(rsp.head) : '0;
  assign next_priority   = any_ready ? PRIO_W'(top) : '0;

  `PRQS_ASSERT_IMP(a_done_after_head, done, $past(state == S_HEAD_RD), "result without head read")
  `PRQS_ASSERT_IMP(a_mask_has_task, |mask, |queued, "level marked ready with no task queued")
  `PRQS_ASSERT_IMP(a_preempt_ok, done && preempt_request, status == ST_OK, "preempt on failed add")
  `PRQS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")

endmodule
`default_nettype wire

@@ sim/tb_priority_ready_queue_scheduler_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the ready-queue scheduler: directed and random
// add, remove, rotate and query words, checked against a queue-based predictor.
// Depends on prqs_pkg and priority_ready_queue_scheduler_core.

import prqs_pkg::*;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic                preempt;
  logic                any;
  logic [ID_W-1:0]     next_task;
  logic [PRIO_W-1:0]   next_prio;
} sched_word_t;

class sched_scoreboard;
  logic [ID_W-1:0]   level_fifo [NUM_LEVELS][$];
  bit                queued [NUM_TASKS];
  logic [PRIO_W-1:0] level_of [NUM_TASKS];
  sched_word_t       pending [$];
  int                errors;
  int                commands;
  int                results;
  int                preempts;
  int                rejects;

  task report_mismatch(input string msg);
    errors++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  function void unlink_task(input logic [ID_W-1:0] id);
    int lvl;
    lvl = level_of[id];
    for (int i = 0; i < level_fifo[lvl].size(); i++) begin
      if (level_fifo[lvl][i] == id) begin
        level_fifo[lvl].delete(i);
        break;
      end
    end
    queued[id] = 1'b0;
  endfunction

  function void note_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio, input logic cur_valid,
                             input logic [PRIO_W-1:0] cur_prio);
    sched_word_t w;
    w = '0;
    w.status = ST_OK;
    commands++;
    case (op)
      OP_ADD: begin
        if (queued[id]) begin
          w.status = ST_QUEUED;
        end else begin
          level_fifo[prio].push_back(id);
          queued[id] = 1'b1;
          level_of[id] = prio;
          w.preempt = cur_valid && (prio > cur_prio);
        end
      end
      OP_REMOVE, OP_ROTATE: begin
        if (!queued[id]) begin
          w.status = ST_NOT_QUEUED;
        end else begin
          unlink_task(id);
          if (op == OP_ROTATE) begin
            level_fifo[level_of[id]].push_back(id);
            queued[id] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // highest non-empty level wins
    for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
      if (level_fifo[lvl].size() != 0) begin
        w.any       = 1'b1;
        w.next_prio = PRIO_W'(lvl);
        w.next_task = level_fifo[lvl][0];
      end
    end
    pending.push_back(w);
  endfunction

  task check_result(input sched_word_t got);
    sched_word_t want;
    results++;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("word with nothing outstanding, next_task %0d", got.next_task));
      return;
    end
    want = pending.pop_front();
    if (got.preempt === 1'b1) preempts++;
    if (want.status != ST_OK) rejects++;
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.preempt !== want.preempt)
      report_mismatch($sformatf("preempt_request %0b, want %0b", got.preempt, want.preempt));
    if (got.any !== want.any)
      report_mismatch($sformatf("any_ready %0b, want %0b", got.any, want.any));
    if (got.next_task !== want.next_task)
      report_mismatch($sformatf("next_task %0d, want %0d", got.next_task, want.next_task));
    if (got.next_prio !== want.next_prio)
      report_mismatch($sformatf("next_priority %0d, want %0d", got.next_prio, want.next_prio));
  endtask
endclass

module tb_priority_ready_queue_scheduler_core;
  localparam int CMD_COUNT   = 1700;
  localparam int CYCLE_LIMIT = 300000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OP_W-1:0]     opcode = OP_QUERY;
  logic [ID_W-1:0]     task_id = '0;
  logic [PRIO_W-1:0]   task_priority = '0;
  logic                current_valid = 1'b0;
  logic [PRIO_W-1:0]   current_priority = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic                preempt_request;
  logic                any_ready;
  logic [ID_W-1:0]     next_task;
  logic [PRIO_W-1:0]   next_priority;

  sched_scoreboard sb = new();
  sched_word_t     seen;
  int              cycle_count = 0;
  int              burst_left;

  priority_ready_queue_scheduler_core uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .task_id          (task_id),
    .task_priority    (task_priority),
    .current_valid    (current_valid),
    .current_priority (current_priority),
    .done             (done),
    .status           (status),
    .preempt_request  (preempt_request),
    .any_ready        (any_ready),
    .next_task        (next_task),
    .next_priority    (next_priority)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               sb.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen = '{status, preempt_request, any_ready, next_task, next_priority};
      sb.check_result(seen);
    end
  end

  // hold start high with the word, then wait until busy falls again
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [PRIO_W-1:0] prio, input logic cv,
                          input logic [PRIO_W-1:0] cp);
    start            <= 1'b1;
    opcode           <= op;
    task_id          <= id;
    task_priority    <= prio;
    current_valid    <= cv;
    current_priority <= cp;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op, id, prio, cv, cp);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_task(input bit want_queued);
    int cand [$];
    for (int t = 0; t < NUM_TASKS; t++) begin
      if (sb.queued[t] == want_queued) cand.push_back(t);
    end
    return ID_W'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  task automatic random_cmd();
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    int              n;
    int              r;
    int              add_w;
    n = 0;
    for (int t = 0; t < NUM_TASKS; t++) n += sb.queued[t];
    r = $urandom_range(0, 99);
    add_w = (n < 6) ? 55 : ((n > 12) ? 20 : 38);
    if (r < add_w && n < NUM_TASKS) begin
      op = OP_ADD;
      id = pick_task(1'b0);
    end else if (r < 80 && n > 0) begin
      op = ($urandom_range(0, 2) == 0) ? OP_ROTATE : OP_REMOVE;
      id = pick_task(1'b1);
    end else if (r < 88) begin
      op = OP_QUERY;
      id = ID_W'($urandom);
    end else begin
      op = OP_W'($urandom);
      id = ID_W'($urandom);
    end
    send_cmd(op, id, PRIO_W'($urandom), 1'($urandom), PRIO_W'($urandom));
  endtask

  task automatic run_directed();
    send_cmd(OP_QUERY,  4'd0,  3'd0, 1'b0, 3'd0);
    send_cmd(OP_ADD,    4'd0,  3'd0, 1'b0, 3'd7);
    send_cmd(OP_ADD,    4'd15, 3'd7, 1'b1, 3'd6);
    send_cmd(OP_ADD,    4'd15, 3'd7, 1'b1, 3'd0);
    send_cmd(OP_REMOVE, 4'd5,  3'd0, 1'b0, 3'd0);
    pause(3);
    send_cmd(OP_ROTATE, 4'd5,  3'd7, 1'b1, 3'd7);
    send_cmd(OP_ADD,    4'd3,  3'd7, 1'b1, 3'd7);
    send_cmd(OP_ADD,    4'd9,  3'd7, 1'b0, 3'd0);
    send_cmd(OP_ROTATE, 4'd15, 3'd0, 1'b0, 3'd0);
    send_cmd(OP_REMOVE, 4'd3,  3'd0, 1'b0, 3'd0);
    send_cmd(OP_ADD,    4'd4,  3'd7, 1'b1, 3'd3);
    pause(1);
    send_cmd(OP_REMOVE, 4'd15, 3'd0, 1'b0, 3'd0);
    send_cmd(OP_REMOVE, 4'd4,  3'd0, 1'b0, 3'd0);
    send_cmd(OP_ROTATE, 4'd9,  3'd0, 1'b0, 3'd0);
    send_cmd(OP_REMOVE, 4'd9,  3'd0, 1'b0, 3'd0);
    send_cmd(OP_ADD,    4'd8,  3'd7, 1'b1, 3'd0);
    send_cmd(OP_ADD,    4'd10, 3'd3, 1'b1, 3'd3);
    send_cmd(OP_QUERY,  4'd15, 3'd7, 1'b1, 3'd7);
    send_cmd(OP_REMOVE, 4'd0,  3'd0, 1'b0, 3'd0);
    send_cmd(OP_REMOVE, 4'd8,  3'd0, 1'b0, 3'd0);
    send_cmd(OP_REMOVE, 4'd10, 3'd0, 1'b0, 3'd0);
    send_cmd(OP_REMOVE, 4'd10, 3'd0, 1'b0, 3'd0);
    send_cmd(OP_QUERY,  4'd0,  3'd0, 1'b0, 3'd0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain();
    burst_left = 0;
    for (int i = 0; i < CMD_COUNT; i++) begin
      if (i % 400 == 399) begin
        drain();
      end else if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 9));
      end
      random_cmd();
      burst_left--;
    end
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d command words, %0d result words, %0d preempt requests,",
             sb.commands, sb.results, sb.preempts);
    $display("%0d rejected adds/removes/rotates, %0d mismatches", sb.rejects, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/prqs_pkg.sv
src/prqs_ram.sv
src/prqs_ctrl.sv
src/priority_ready_queue_scheduler_core.sv
sim/tb_priority_ready_queue_scheduler_core.sv
